[sv/ted_pkg.sv]
// Shared types, constants and letter tables for the text encoding detector.
// No dependencies; used by ted_bigram and text_encoding_detector.
package ted_pkg;

    localparam int LENGTH_BITS_DEF = 24;

    typedef enum logic [3:0] {
        TXT_UNKNOWN   = 4'd0,
        TXT_ASCII     = 4'd1,
        TXT_UTF8      = 4'd2,
        TXT_UTF16LE   = 4'd3,
        TXT_UTF16BE   = 4'd4,
        TXT_CP1251    = 4'd5,
        TXT_KOI8R     = 4'd6,
        TXT_CP866     = 4'd7,
        TXT_ISO8859_1 = 4'd8
    } t_encoding;

    typedef enum logic [1:0] {
        CS_WIN = 2'd0,
        CS_ALT = 2'd1,
        CS_KOI = 2'd2
    } t_charset;

    typedef struct packed {
        logic step;
        logic clear;
    } t_bigram_ctrl;

    typedef logic [5:0] t_letter;
    typedef logic [0:31] t_pair_row;

    localparam t_letter KOI_LETTERS [32] = '{
        6'd31, 6'd1,  6'd2,  6'd23, 6'd5,  6'd6,  6'd21, 6'd4,
        6'd22, 6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
        6'd16, 6'd32, 6'd17, 6'd18, 6'd19, 6'd20, 6'd7,  6'd3,
        6'd29, 6'd28, 6'd8,  6'd25, 6'd30, 6'd26, 6'd24, 6'd27
    };

    // Row is the previous letter, column the current one, both counted from zero.
    localparam t_pair_row PAIR_OK [32] = '{
        32'b11111111_11111111_11111111_11000111,
        32'b11111110_10111110_11110111_11111011,
        32'b11111101_10111111_11110111_11111001,
        32'b11111100_10111110_11110001_10000000,
        32'b11111111_11111111_11110111_10111011,
        32'b11111111_11111111_11111111_11001111,
        32'b11011110_10111111_11010001_00001000,
        32'b11111111_10111111_11110001_10111111,
        32'b11111111_11111111_11111111_11000111,
        32'b00011101_00111111_01111111_10000001,
        32'b10100111_10110110_11110010_10000010,
        32'b11111111_11111111_01110101_11011011,
        32'b11111100_10111111_11010111_10011101,
        32'b11111111_10101110_11111011_11011111,
        32'b11111111_11111111_11111111_11000111,
        32'b10000100_10110111_11110011_10011111,
        32'b11111111_11111111_11111111_11011011,
        32'b11111111_10111111_11111111_11111111,
        32'b11111101_10111111_11111111_11111111,
        32'b11111111_11111111_11100111_11000111,
        32'b10000100_10011110_11110000_00010010,
        32'b10111100_10111111_11110000_10000100,
        32'b10100100_10111010_00010000_00010000,
        32'b10100100_10111110_10111000_10001000,
        32'b10101100_10111111_11110111_00001010,
        32'b10000100_10000110_10010000_00001000,
        32'b00000100_00000000_00000000_00000011,
        32'b01111111_11111101_11110111_11000001,
        32'b01111101_10101110_01101111_11001011,
        32'b00010101_00011101_11111100_00000000,
        32'b01111111_01111101_11100111_11000010,
        32'b01111111_11111101_11110111_11000011
    };

    // Letter index 1..32 of a byte in a Cyrillic code page, 0 if not a letter.
    function automatic t_letter letter_of(t_charset cs, logic [7:0] b);
        t_letter v;
        v = '0;
        if (b[7]) begin
            case (cs)
                CS_WIN: begin
                    if (b[6]) v = {1'b0, b[4:0]} + 6'd1;
                end
                CS_ALT: begin
                    if (b[6:5] == 2'b00) begin
                        v = {1'b0, b[4:0]} + 6'd1;
                    end else if (b[6:4] == 3'b010) begin
                        v = {2'b00, b[3:0]} + 6'd1;
                    end else if (b[6:4] == 3'b110) begin
                        v = {2'b00, b[3:0]} + 6'd17;
                    end
                end
                CS_KOI: begin
                    if (b[6]) v = KOI_LETTERS[b[4:0]];
                end
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

[sv/ted_bigram.sv]
// Bigram counter for one Cyrillic code page: letter decode, pair check, count.
// Depends on ted_pkg for the letter tables and the control struct.
module ted_bigram import ted_pkg::*; #(
    parameter int       LENGTH_BITS = LENGTH_BITS_DEF,
    parameter t_charset CHARSET     = CS_WIN
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_bigram_ctrl           i_ctrl,
    input  logic [7:0]             i_text_byte,
    output logic [LENGTH_BITS-1:0] o_count_next
);

    logic [LENGTH_BITS-1:0] r_count;
    logic [LENGTH_BITS-1:0] n_count;
    t_letter                r_prev;
    t_letter                letter;
    logic                   pair_hit;
    logic [4:0]             row_idx;
    logic [4:0]             col_idx;
    t_pair_row              pair_row;

    always_comb begin
        letter   = letter_of(CHARSET, i_text_byte);
        row_idx  = 5'(r_prev - 6'd1);
        col_idx  = 5'(letter - 6'd1);
        pair_row = PAIR_OK[row_idx];
        pair_hit = (letter != '0) && (r_prev != '0) && pair_row[col_idx];
        n_count  = (pair_hit && !(&r_count)) ? r_count + LENGTH_BITS'(1) : r_count;
        o_count_next = i_ctrl.step ? n_count : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_count <= '0;
            r_prev  <= '0;
        end else if (i_ctrl.step) begin
            r_count <= n_count;
            r_prev  <= letter;
        end
    end

endmodule

[sv/text_encoding_detector.sv]
// Text encoding detector: takes one byte per cycle and reports the encoding of the text.
// The final byte is registered in the input stage and then loads the result register.
// Throughput: one byte per cycle; the input stage stalls only when a final byte
// meets a full result register that is not being taken.
// Reset is synchronous and clears all running state at once; state also clears
// after each final byte. Depends on ted_pkg and ted_bigram.
module text_encoding_detector import ted_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_encoding
);

    localparam int WIDE_BITS = LENGTH_BITS + 4;

    // Input stage.
    logic       r_s1_valid;
    logic       r_s1_last;
    logic [7:0] r_s1_byte;
    logic       s1_adv;

    // Running state.
    logic [7:0]             r_head [3];
    logic [LENGTH_BITS-1:0] r_byte_count;
    logic [LENGTH_BITS-1:0] n_byte_count;
    logic                   r_zero_seen;
    logic                   n_zero_seen;
    logic [2:0]             r_utf8_pending;
    logic [2:0]             n_utf8_pending;
    logic                   r_utf8_invalid;
    logic                   n_utf8_invalid;
    logic                   r_utf8_doubt;
    logic                   n_utf8_doubt;
    logic                   r_non_ascii;
    logic                   n_non_ascii;
    logic [7:0]             n_head [3];
    logic [2:0]             pending_dec;

    t_bigram_ctrl           bg_ctrl;
    logic [LENGTH_BITS-1:0] cnt_win;
    logic [LENGTH_BITS-1:0] cnt_alt;
    logic [LENGTH_BITS-1:0] cnt_koi;

    // Result stage.
    logic      r_out_valid;
    t_encoding r_encoding;
    t_encoding n_encoding;

    assign s1_adv     = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_byte <= i_text_byte;
            r_s1_last <= i_is_last;
        end
    end

    always_comb begin
        n_head = r_head;
        if (r_byte_count < LENGTH_BITS'(3)) begin
            n_head[r_byte_count[1:0]] = r_s1_byte;
        end
        n_byte_count = (&r_byte_count) ? r_byte_count : r_byte_count + LENGTH_BITS'(1);
        n_zero_seen  = r_zero_seen || (r_s1_byte == 8'h00);
        n_non_ascii  = r_non_ascii || (!n_zero_seen && r_s1_byte[7]);
    end

    // UTF-8 validity scan.
    always_comb begin
        pending_dec    = r_utf8_pending - 3'd1;
        n_utf8_pending = r_utf8_pending;
        n_utf8_invalid = r_utf8_invalid;
        n_utf8_doubt   = r_utf8_doubt;
        if (r_utf8_doubt) begin
            n_utf8_pending = pending_dec;
            if (pending_dec == 3'd0) begin
                n_utf8_invalid = 1'b1;
                n_utf8_doubt   = 1'b0;
            end
        end else if (r_utf8_invalid || n_zero_seen) begin
            n_utf8_pending = r_utf8_pending;
        end else if (r_utf8_pending != 3'd0) begin
            n_utf8_pending = pending_dec;
            if (r_s1_byte[7:6] != 2'b10) begin
                if (pending_dec == 3'd0) begin
                    n_utf8_invalid = 1'b1;
                end else begin
                    n_utf8_doubt = 1'b1;
                end
            end
        end else if (r_s1_byte[7]) begin
            if (r_s1_byte[6:5] == 2'b10) begin
                n_utf8_pending = 3'd1;
            end else if (r_s1_byte[6:4] == 3'b110) begin
                n_utf8_pending = 3'd2;
            end else if (r_s1_byte[6:3] == 4'b1110) begin
                n_utf8_pending = 3'd3;
            end else if (r_s1_byte[6:2] == 5'b11110) begin
                n_utf8_pending = 3'd4;
            end else if (r_s1_byte[6:1] == 6'b111110) begin
                n_utf8_pending = 3'd5;
            end else begin
                n_utf8_invalid = 1'b1;
            end
        end
    end

    assign bg_ctrl.step  = s1_adv && !n_zero_seen;
    assign bg_ctrl.clear = s1_adv && r_s1_last;

    ted_bigram #(.LENGTH_BITS(LENGTH_BITS), .CHARSET(CS_WIN)) u_bigram_win (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (bg_ctrl),
        .i_text_byte  (r_s1_byte),
        .o_count_next (cnt_win)
    );

    ted_bigram #(.LENGTH_BITS(LENGTH_BITS), .CHARSET(CS_ALT)) u_bigram_alt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (bg_ctrl),
        .i_text_byte  (r_s1_byte),
        .o_count_next (cnt_alt)
    );

    ted_bigram #(.LENGTH_BITS(LENGTH_BITS), .CHARSET(CS_KOI)) u_bigram_koi (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (bg_ctrl),
        .i_text_byte  (r_s1_byte),
        .o_count_next (cnt_koi)
    );

    // A count beats a tenth of the length exactly when ten times the count exceeds it.
    logic [WIDE_BITS-1:0] len_wide;
    logic [WIDE_BITS-1:0] win_x10;
    logic [WIDE_BITS-1:0] alt_x10;
    logic [WIDE_BITS-1:0] koi_x10;

    always_comb begin
        len_wide = WIDE_BITS'(n_byte_count);
        win_x10  = (WIDE_BITS'(cnt_win) << 3) + (WIDE_BITS'(cnt_win) << 1);
        alt_x10  = (WIDE_BITS'(cnt_alt) << 3) + (WIDE_BITS'(cnt_alt) << 1);
        koi_x10  = (WIDE_BITS'(cnt_koi) << 3) + (WIDE_BITS'(cnt_koi) << 1);

        if (n_head[0] == 8'h00 || n_byte_count < LENGTH_BITS'(2)) begin
            n_encoding = TXT_UNKNOWN;
        end else if (n_head[0] == 8'hFF && n_head[1] == 8'hFE) begin
            n_encoding = TXT_UTF16LE;
        end else if (n_head[0] == 8'hFE && n_head[1] == 8'hFF) begin
            n_encoding = TXT_UTF16BE;
        end else if (n_byte_count > LENGTH_BITS'(2) && n_head[0] == 8'hEF &&
                     n_head[1] == 8'hBB && n_head[2] == 8'hBF) begin
            n_encoding = TXT_UTF8;
        end else if (!n_utf8_invalid) begin
            n_encoding = n_non_ascii ? TXT_UTF8 : TXT_ASCII;
        end else if (!n_non_ascii) begin
            n_encoding = TXT_ASCII;
        end else if (cnt_win > cnt_alt && cnt_win > cnt_koi && win_x10 > len_wide) begin
            n_encoding = TXT_CP1251;
        end else if (cnt_alt > cnt_win && cnt_alt > cnt_koi && alt_x10 > len_wide) begin
            n_encoding = TXT_CP866;
        end else if (cnt_koi > cnt_win && cnt_koi > cnt_alt && koi_x10 > len_wide) begin
            n_encoding = TXT_KOI8R;
        end else begin
            n_encoding = TXT_ISO8859_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_adv && r_s1_last)) begin
            r_head         <= '{default: 8'h00};
            r_byte_count   <= '0;
            r_zero_seen    <= 1'b0;
            r_utf8_pending <= '0;
            r_utf8_invalid <= 1'b0;
            r_utf8_doubt   <= 1'b0;
            r_non_ascii    <= 1'b0;
        end else if (s1_adv) begin
            r_head         <= n_head;
            r_byte_count   <= n_byte_count;
            r_zero_seen    <= n_zero_seen;
            r_utf8_pending <= n_utf8_pending;
            r_utf8_invalid <= n_utf8_invalid;
            r_utf8_doubt   <= n_utf8_doubt;
            r_non_ascii    <= n_non_ascii;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_encoding <= n_encoding;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_encoding  = r_encoding;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (r_byte_count == '0 && !r_utf8_invalid && !r_zero_seen))
        else $error("running state not cleared after the final byte");

    a_doubt_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_utf8_doubt |-> (r_utf8_pending != 3'd0 && !r_utf8_invalid))
        else $error("UTF-8 doubt held without an open sequence");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s1_last && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked final byte");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> o_out_valid)
        else $error("final byte advanced without a result");

endmodule
